// ===== hw/rtl/patlb_pkg.sv =====
// Package for the paged address translator: widths, default sizes,
// outcome codes, controller states and controller/datapath signal groups.
// No dependencies.
package patlb_pkg;

  localparam int ADDR_W      = 16;
  localparam int OFFSET_BITS = 8;
  localparam int PAGE_W      = ADDR_W - OFFSET_BITS;
  localparam int CNT_W       = 32;
  localparam int WIDE_W      = 32;

  localparam int TLB_ENTRIES_DEF = 16;
  localparam int NUM_PAGES_DEF   = 256;
  localparam int NUM_FRAMES_DEF  = 256;

  typedef enum logic [1:0] {
    OUT_TLB_HIT = 2'd0,
    OUT_PT_HIT  = 2'd1,
    OUT_FAULT   = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_RESOLVE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_en;
    logic load;
    logic lookup;
    logic resolve;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
  } status_t;

endpackage

// ===== hw/rtl/patlb_ctrl.sv =====
// Controller for the paged address translator: clear pass, then
// accept / lookup / resolve sequencing. Depends on patlb_pkg.
module patlb_ctrl
  import patlb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== hw/rtl/patlb_dp.sv =====
// Datapath for the paged address translator: TLB shift line, page table
// memory, frame allocator, saturating counters, result registers.
// Depends on patlb_pkg.
module patlb_dp
  import patlb_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int NUM_PAGES   = NUM_PAGES_DEF,
  parameter int NUM_FRAMES  = NUM_FRAMES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [ADDR_W-1:0] in_logical_address,
  output logic              out_valid,
  output logic [ADDR_W-1:0] out_phys_addr,
  output logic [1:0]        out_outcome,
  output logic [CNT_W-1:0]  out_tlb_hit_total,
  output logic [CNT_W-1:0]  out_fault_total
);

  localparam int FILL_W  = $clog2(TLB_ENTRIES + 1);
  localparam int FRAME_W = $clog2(NUM_FRAMES);
  localparam int FCNT_W  = $clog2(NUM_FRAMES + 1);
  localparam int PIDX_W  = $clog2(NUM_PAGES);

  logic [ADDR_W-1:0]      addr_r;
  logic [PAGE_W-1:0]      page;
  logic [OFFSET_BITS-1:0] offset;
  logic [WIDE_W-1:0]      page_wide;
  logic [PIDX_W-1:0]      pidx;

  assign page      = addr_r[ADDR_W-1:OFFSET_BITS];
  assign offset    = addr_r[OFFSET_BITS-1:0];
  assign page_wide = WIDE_W'(page);
  assign pidx      = page_wide[PIDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= in_logical_address;
    end
  end

  // TLB: shift line, entries below fill_r are live
  logic [PAGE_W-1:0]  tlb_page_r  [TLB_ENTRIES];
  logic [FRAME_W-1:0] tlb_frame_r [TLB_ENTRIES];
  logic [FILL_W-1:0]  fill_r;
  logic [TLB_ENTRIES-1:0] match;
  logic [FRAME_W-1:0] match_frame;

  always_comb begin
    match_frame = '0;
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      match[k] = (FILL_W'(k) < fill_r) && (tlb_page_r[k] == page);
      if (match[k]) begin
        match_frame = match_frame | tlb_frame_r[k];
      end
    end
  end

  // page table: {valid, frame}
  logic [FRAME_W:0] pt_mem [NUM_PAGES];
  logic [FRAME_W:0] pt_rd_r;
  logic             hit_r;
  logic [FRAME_W-1:0] hit_frame_r;
  logic             in_range_r;
  logic [PIDX_W-1:0] clr_r;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      pt_rd_r     <= pt_mem[pidx];
      hit_r       <= |match;
      hit_frame_r <= match_frame;
      in_range_r  <= page_wide < WIDE_W'(NUM_PAGES);
    end
  end

  // resolve
  logic [FCNT_W-1:0]  alloc_r;
  logic               exhausted;
  logic               pt_valid;
  logic               fault;
  logic [FRAME_W-1:0] alloc_frame;
  logic [FRAME_W-1:0] frame;
  outcome_t           outcome;
  logic [WIDE_W-1:0]  phys_wide;

  assign exhausted   = alloc_r == FCNT_W'(NUM_FRAMES);
  assign alloc_frame = exhausted ? '0 : alloc_r[FRAME_W-1:0];
  assign pt_valid    = in_range_r & pt_rd_r[FRAME_W];
  assign fault       = !hit_r && !pt_valid;

  always_comb begin
    if (hit_r) begin
      outcome = OUT_TLB_HIT;
      frame   = hit_frame_r;
    end else if (pt_valid) begin
      outcome = OUT_PT_HIT;
      frame   = pt_rd_r[FRAME_W-1:0];
    end else begin
      outcome = OUT_FAULT;
      frame   = alloc_frame;
    end
  end

  assign phys_wide = (WIDE_W'(frame) << OFFSET_BITS) | WIDE_W'(offset);

  // single write port: clear pass or fault fill
  logic              wr_en;
  logic [PIDX_W-1:0] wr_addr;
  logic [FRAME_W:0]  wr_data;

  always_comb begin
    if (cmd.clear_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else begin
      wr_en   = cmd.resolve && fault && in_range_r;
      wr_addr = pidx;
      wr_data = {1'b1, alloc_frame};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pt_mem[wr_addr] <= wr_data;
    end
  end

  assign status.clear_last = clr_r == PIDX_W'(NUM_PAGES - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_en) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // TLB insert on every miss
  logic tlb_full;
  assign tlb_full = fill_r == FILL_W'(TLB_ENTRIES);

  always_ff @(posedge clk) begin
    if (cmd.resolve && !hit_r) begin
      if (tlb_full) begin
        for (int k = 0; k < TLB_ENTRIES - 1; k++) begin
          tlb_page_r[k]  <= tlb_page_r[k+1];
          tlb_frame_r[k] <= tlb_frame_r[k+1];
        end
        tlb_page_r[TLB_ENTRIES-1]  <= page;
        tlb_frame_r[TLB_ENTRIES-1] <= frame;
      end else begin
        for (int k = 0; k < TLB_ENTRIES; k++) begin
          if (FILL_W'(k) == fill_r) begin
            tlb_page_r[k]  <= page;
            tlb_frame_r[k] <= frame;
          end
        end
      end
    end
  end

  logic [CNT_W-1:0] hit_cnt_r;
  logic [CNT_W-1:0] fault_cnt_r;
  logic             valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      alloc_r     <= '0;
      hit_cnt_r   <= '0;
      fault_cnt_r <= '0;
      valid_r     <= 1'b0;
    end else begin
      valid_r <= cmd.resolve;
      if (cmd.resolve) begin
        if (!hit_r && !tlb_full) begin
          fill_r <= fill_r + 1'b1;
        end
        if (fault && !exhausted) begin
          alloc_r <= alloc_r + 1'b1;
        end
        if (hit_r && !(&hit_cnt_r)) begin
          hit_cnt_r <= hit_cnt_r + 1'b1;
        end
        if (fault && !(&fault_cnt_r)) begin
          fault_cnt_r <= fault_cnt_r + 1'b1;
        end
      end
    end
  end

  logic [ADDR_W-1:0] phys_r;
  logic [1:0]        outcome_r;

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      phys_r    <= phys_wide[ADDR_W-1:0];
      outcome_r <= outcome;
    end
  end

  assign out_valid         = valid_r;
  assign out_phys_addr     = phys_r;
  assign out_outcome       = outcome_r;
  assign out_tlb_hit_total = hit_cnt_r;
  assign out_fault_total   = fault_cnt_r;

endmodule

// ===== hw/rtl/paged_address_translator_tlb_top.sv =====
// Top level of the paged address translator with FIFO TLB.
// Instantiates patlb_ctrl and patlb_dp; depends on patlb_pkg.
//
// Usage:
//  - Input: drive in_logical_address and raise start; the word is taken at
//    the rising edge where start is high and busy is low.
//  - Each word makes exactly one result. out_valid is high for one cycle
//    with physical address, outcome (TLB hit / page table hit / fault) and
//    the saturating hit and fault totals, both counting this word.
//  - Timing: accept edge, then a lookup state (TLB compare plus page table
//    read), then a resolve state (table write, TLB shift, counters). The result
//    is registered at the end of the resolve state; busy drops at the same
//    time, so a new word can go in while out_valid is high. A new word waits
//    for the page table read of the last word and its write-back.
//  - Reset (rst_n low, synchronous) clears TLB fill, frame allocator and
//    counters, then runs a clearing pass over the page table valid bits,
//    with busy high until every entry is cleared, before the first word is taken.
//  - The receiver has no back-pressure; a result not captured is gone.
module paged_address_translator_tlb_top
  import patlb_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int NUM_PAGES   = NUM_PAGES_DEF,
  parameter int NUM_FRAMES  = NUM_FRAMES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [ADDR_W-1:0] in_logical_address,
  output logic              out_valid,
  output logic [ADDR_W-1:0] out_phys_addr,
  output logic [1:0]        out_outcome,
  output logic [CNT_W-1:0]  out_tlb_hit_total,
  output logic [CNT_W-1:0]  out_fault_total
);

  cmd_t    cmd;
  status_t status;

  // sequencing: clear pass, idle, lookup, resolve
  patlb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // TLB, page table, allocator, counters
  patlb_dp #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .NUM_PAGES   (NUM_PAGES),
    .NUM_FRAMES  (NUM_FRAMES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_logical_address (in_logical_address),
    .out_valid          (out_valid),
    .out_phys_addr      (out_phys_addr),
    .out_outcome        (out_outcome),
    .out_tlb_hit_total  (out_tlb_hit_total),
    .out_fault_total    (out_fault_total)
  );

endmodule
